// ===== hdl/bitmap_contiguous_page_allocator_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define BPA_ASSERT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int PAGE_SLOTS_DEF = 1024;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

endpackage

// ===== hdl/bpa_ram.sv =====
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bpa_mask.sv =====
`timescale 1ns / 1ps

module bpa_mask
    import bpa_pkg::*;
#(
    parameter int PIW = 10
) (
    input  logic [PIW-BIT_W-1:0] i_word,
    input  logic [PIW-1:0]       i_lo,
    input  logic [PIW-1:0]       i_hi,
    output logic [WORD_W-1:0]    o_mask
);

    logic [BIT_W-1:0] lo_off;
    logic [BIT_W-1:0] hi_off;

    // bits of this word that fall inside the page range lo..hi
    always_comb begin
        lo_off = (i_word == i_lo[PIW-1:BIT_W]) ? i_lo[BIT_W-1:0] : '0;
        hi_off = (i_word == i_hi[PIW-1:BIT_W]) ? i_hi[BIT_W-1:0] : BIT_W'(WORD_W - 1);
        o_mask = ({WORD_W{1'b1}} << lo_off)
               & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_off));
    end

endmodule

// ===== hdl/bitmap_contiguous_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// first-fit page allocator over a one-bit-per-page usage map
// input channel: i_in_valid / o_in_stall carry one request (opcode, num_pages,
//   first_page); a request is taken when valid is high and stall is low
// output channel: o_out_valid / i_out_stall carry one response (status,
//   alloc_page) for every request, in request order
// the map sits in a 32-bit wide ram, one word read or written per cycle
// allocate: the request is taken, then the sequencer reads word by word
//   from page 0; an all-free or all-used word is judged whole after its read, a
//   mixed word is walked bit by bit, then each word of the run is read and
//   written back marked, then the response is posted
// free: each touched word is read then rewritten; zero count or bad range fails
// the block takes one request at a time and stalls its input meanwhile
// reset: the map is rewritten one word per cycle, page 0 marked used, the input
//   stalled meanwhile
// a response held by a stalled receiver stays put; the next request is still
//   taken and worked on, and waits for the output register only at its end
module bitmap_contiguous_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [10:0] i_num_pages,
    input  logic [9:0]  i_first_page,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [9:0]  o_alloc_page
);

    localparam int NW   = (PAGE_SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int PIW  = AW + BIT_W;
    localparam int CMPW = (PIW + 1 > 12) ? PIW + 1 : 12;

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_SCAN_RD   = 8'b0000_0100,
        S_SCAN_EVAL = 8'b0000_1000,
        S_SCAN_BIT  = 8'b0001_0000,
        S_MARK_RD   = 8'b0010_0000,
        S_MARK_WR   = 8'b0100_0000,
        S_RESP      = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [10:0]       r_cnt, n_cnt;
    logic [10:0]       r_run, n_run;
    logic [PIW-1:0]    r_head, n_head;
    logic [PIW-1:0]    r_lo, n_lo;
    logic [PIW-1:0]    r_hi, n_hi;
    logic              r_fill, n_fill;
    logic [WORD_W-1:0] r_word, n_word;
    t_status           r_res_status, n_res_status;
    logic [PIW-1:0]    r_res_start, n_res_start;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [9:0]        r_out_start, n_out_start;

    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [PIW-1:0]    mask_lo;
    logic [PIW-1:0]    mask_hi;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic [PIW-1:0]    base_page;
    logic [PIW-1:0]    cur_page;
    logic [PIW-1:0]    head_found;
    logic [CMPW-1:0]   free_end;
    logic [CMPW-1:0]   free_last;
    logic [CMPW-1:0]   alloc_last;
    logic [11:0]       run_p32;
    logic [11:0]       run_p1;
    logic [PIW+9:0]    first_ext;
    logic [PIW+9:0]    start_ext;
    logic              out_free;
    logic              last_word;
    logic              next_word;

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // one shifter builds both the in-map mask for scanning and the run mask
    bpa_mask #(
        .PIW (PIW)
    ) u_mask (
        .i_word (r_addr),
        .i_lo   (mask_lo),
        .i_hi   (mask_hi),
        .o_mask (mask)
    );

    always_comb begin
        if (r_state == S_MARK_WR) begin
            mask_lo = r_lo;
            mask_hi = r_hi;
        end else begin
            mask_lo = '0;
            mask_hi = PIW'(PAGE_SLOTS - 1);
        end
    end

    always_comb begin
        free_bits  = ~ram_rdata & mask;
        base_page  = {r_addr, {BIT_W{1'b0}}};
        cur_page   = {r_addr, r_bit};
        run_p32    = {1'b0, r_run} + 12'(WORD_W);
        run_p1     = {1'b0, r_run} + 12'd1;
        first_ext  = {{PIW{1'b0}}, i_first_page};
        free_end   = CMPW'(i_first_page) + CMPW'(i_num_pages);
        free_last  = free_end - CMPW'(1);
        start_ext  = {10'd0, r_res_start};
        out_free   = !r_out_valid || !i_out_stall;
        last_word  = (r_addr == AW'(NW - 1));
        if (r_state == S_SCAN_BIT) begin
            head_found = (r_run == '0) ? cur_page : r_head;
        end else begin
            head_found = (r_run == '0) ? base_page : r_head;
        end
        alloc_last = CMPW'(head_found) + CMPW'(r_cnt) - CMPW'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_bit        = r_bit;
        n_cnt        = r_cnt;
        n_run        = r_run;
        n_head       = r_head;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_fill       = r_fill;
        n_word       = r_word;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        ram_we       = 1'b0;
        ram_wdata    = '0;
        next_word    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_addr == '0) ? WORD_W'(1) : '0;
                if (last_word) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt       = i_num_pages;
                    n_res_start = '0;
                    if (i_num_pages == '0) begin
                        n_res_status = ST_BAD;
                        n_state      = S_RESP;
                    end else if (i_opcode == OP_FREE) begin
                        if (free_end > CMPW'(PAGE_SLOTS)) begin
                            n_res_status = ST_BAD;
                            n_state      = S_RESP;
                        end else begin
                            n_lo    = first_ext[PIW-1:0];
                            n_hi    = free_last[PIW-1:0];
                            n_fill  = 1'b0;
                            n_addr  = first_ext[PIW-1:BIT_W];
                            n_state = S_MARK_RD;
                        end
                    end else begin
                        n_run   = '0;
                        n_addr  = '0;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                if (free_bits == mask && mask == {WORD_W{1'b1}}) begin
                    if (run_p32 >= {1'b0, r_cnt}) begin
                        n_lo    = head_found;
                        n_hi    = alloc_last[PIW-1:0];
                        n_fill  = 1'b1;
                        n_addr  = head_found[PIW-1:BIT_W];
                        n_state = S_MARK_RD;
                    end else begin
                        n_head    = head_found;
                        n_run     = run_p32[10:0];
                        next_word = 1'b1;
                    end
                end else if (free_bits == '0) begin
                    n_run     = '0;
                    next_word = 1'b1;
                end else begin
                    // mixed word: walk it one page per cycle
                    n_word  = free_bits;
                    n_bit   = '0;
                    n_state = S_SCAN_BIT;
                end
            end
            S_SCAN_BIT: begin
                if (r_word[r_bit]) begin
                    if (run_p1 == {1'b0, r_cnt}) begin
                        n_lo    = head_found;
                        n_hi    = alloc_last[PIW-1:0];
                        n_fill  = 1'b1;
                        n_addr  = head_found[PIW-1:BIT_W];
                        n_state = S_MARK_RD;
                    end else begin
                        n_head = head_found;
                        n_run  = run_p1[10:0];
                        if (r_bit == BIT_W'(WORD_W - 1)) begin
                            next_word = 1'b1;
                        end else begin
                            n_bit = r_bit + BIT_W'(1);
                        end
                    end
                end else begin
                    n_run = '0;
                    if (r_bit == BIT_W'(WORD_W - 1)) begin
                        next_word = 1'b1;
                    end else begin
                        n_bit = r_bit + BIT_W'(1);
                    end
                end
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_fill ? (ram_rdata | mask) : (ram_rdata & ~mask);
                if (r_addr == r_hi[PIW-1:BIT_W]) begin
                    n_res_status = ST_DONE;
                    n_res_start  = r_fill ? r_lo : '0;
                    n_state      = S_RESP;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_MARK_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = start_ext[9:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase

        // end of a scanned word: move on, or give up after the last one
        if (next_word) begin
            if (last_word) begin
                n_res_status = ST_NOSPACE;
                n_res_start  = '0;
                n_state      = S_RESP;
            end else begin
                n_addr  = r_addr + AW'(1);
                n_state = S_SCAN_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit        <= n_bit;
        r_cnt        <= n_cnt;
        r_run        <= n_run;
        r_head       <= n_head;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_fill       <= n_fill;
        r_word       <= n_word;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_alloc_page = r_out_start;

endmodule

// ===== hdl/bpa_checker.sv =====
`timescale 1ns / 1ps
`include "bitmap_contiguous_page_allocator_unit_assert.svh"

module bpa_checker
    import bpa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_opcode,
    input logic [10:0] i_num_pages,
    input logic [9:0]  i_first_page,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [9:0]  o_alloc_page
);

    // held response keeps its value
    `BPA_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_alloc_page), "stalled response changed")

    // only a successful request reports a start page
    `BPA_ASSERT_IMP(a_fail_zero, o_out_valid && (o_status != ST_DONE), o_alloc_page == 10'd0, "failed request with nonzero start page")

    // map rewrite after reset blocks new requests
    `BPA_ASSERT_ANY(a_rst_stall, !i_rst_n, o_in_stall, "request taken right after reset")

    // one request at a time
    `BPA_ASSERT_NXT(a_busy, i_in_valid && !o_in_stall, o_in_stall, "second request taken back to back")

endmodule

bind bitmap_contiguous_page_allocator_unit bpa_checker u_bpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_opcode     (i_opcode),
    .i_num_pages  (i_num_pages),
    .i_first_page (i_first_page),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_alloc_page (o_alloc_page)
);

// ===== tb/bitmap_contiguous_page_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module bitmap_contiguous_page_allocator_unit_tb;
    import bpa_pkg::*;

    localparam int N_PAGES        = PAGE_SLOTS_DEF;
    localparam int N_DIR          = 25;
    localparam int N_RANDOM       = 1700;
    localparam int N_TOTAL        = N_DIR + N_RANDOM;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        t_status    status;
        logic [9:0] alloc_page;
    } t_resp;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } t_page_run;

    typedef struct {
        t_opcode     op;
        logic [10:0] count;
        logic [9:0]  first;
        bit          typed;
        t_status     status;
        logic [9:0]  alloc_page;
    } t_dir_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic        i_opcode     = 1'b0;
    logic [10:0] i_num_pages  = '0;
    logic [9:0]  i_first_page = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_alloc_page;

    bitmap_contiguous_page_allocator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_num_pages  (i_num_pages),
        .i_first_page (i_first_page),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_alloc_page (o_alloc_page)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the allocation map and of the runs handed out so far
    bit [N_PAGES-1:0] used_map;
    t_page_run        live_runs[$];
    t_resp            expected_resp_q[$];
    t_dir_row         dir_table[N_DIR];

    int  fail_count = 0;
    int  req_idx    = 0;
    int  quiet_left = 0;
    int  in_gap     = 0;
    int  out_hold   = 0;
    int  idle_count = 0;
    bit  all_sent   = 1'b0;
    bit  cur_typed  = 1'b0;
    t_resp cur_typed_resp;

    initial begin
        used_map    = '0;
        used_map[0] = 1'b1;
        dir_table[0]  = '{OP_ALLOC, 11'd1,    10'd1023, 1'b1, ST_DONE,    10'd1};
        dir_table[1]  = '{OP_ALLOC, 11'd0,    10'd0,    1'b1, ST_BAD,     10'd0};
        dir_table[2]  = '{OP_FREE,  11'd0,    10'd5,    1'b1, ST_BAD,     10'd0};
        dir_table[3]  = '{OP_ALLOC, 11'd1025, 10'd0,    1'b1, ST_NOSPACE, 10'd0};
        dir_table[4]  = '{OP_ALLOC, 11'd1024, 10'd0,    1'b1, ST_NOSPACE, 10'd0};
        dir_table[5]  = '{OP_FREE,  11'd25,   10'd1000, 1'b1, ST_BAD,     10'd0};
        dir_table[6]  = '{OP_FREE,  11'd1,    10'd1023, 1'b1, ST_DONE,    10'd0};
        dir_table[7]  = '{OP_ALLOC, 11'd1022, 10'd512,  1'b1, ST_DONE,    10'd2};
        dir_table[8]  = '{OP_ALLOC, 11'd1,    10'd0,    1'b1, ST_NOSPACE, 10'd0};
        // clears the reserved page as well
        dir_table[9]  = '{OP_FREE,  11'd1024, 10'd0,    1'b1, ST_DONE,    10'd0};
        dir_table[10] = '{OP_ALLOC, 11'd1024, 10'd0,    1'b1, ST_DONE,    10'd0};
        dir_table[11] = '{OP_ALLOC, 11'd1,    10'd0,    1'b1, ST_NOSPACE, 10'd0};
        dir_table[12] = '{OP_FREE,  11'd2047, 10'd1023, 1'b1, ST_BAD,     10'd0};
        dir_table[13] = '{OP_FREE,  11'd1,    10'd1023, 1'b1, ST_DONE,    10'd0};
        dir_table[14] = '{OP_ALLOC, 11'd1,    10'd0,    1'b1, ST_DONE,    10'd1023};
        dir_table[15] = '{OP_FREE,  11'd1024, 10'd0,    1'b1, ST_DONE,    10'd0};
        dir_table[16] = '{OP_ALLOC, 11'd3,    10'd0,    1'b1, ST_DONE,    10'd0};
        dir_table[17] = '{OP_ALLOC, 11'd2047, 10'd0,    1'b1, ST_NOSPACE, 10'd0};
        dir_table[18] = '{OP_FREE,  11'd0,    10'd1023, 1'b1, ST_BAD,     10'd0};
        // pages already free
        dir_table[19] = '{OP_FREE,  11'd10,   10'd500,  1'b1, ST_DONE,    10'd0};
        dir_table[20] = '{OP_ALLOC, 11'd5,    10'd77,   1'b0, ST_DONE,    10'd0};
        dir_table[21] = '{OP_FREE,  11'd2,    10'd1,    1'b0, ST_DONE,    10'd0};
        dir_table[22] = '{OP_ALLOC, 11'd2,    10'd0,    1'b0, ST_DONE,    10'd0};
        dir_table[23] = '{OP_ALLOC, 11'd1016, 10'd0,    1'b0, ST_DONE,    10'd0};
        dir_table[24] = '{OP_FREE,  11'd1024, 10'd0,    1'b0, ST_DONE,    10'd0};
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) return 0;
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 200);
    endfunction

    // first-fit allocate / range free on the shadow map
    task automatic predict_allocation(input t_opcode op, input logic [10:0] count,
                                      input logic [9:0] first, output t_resp resp);
        int unsigned cnt_i;
        int unsigned first_i;
        int unsigned run_len;
        int unsigned head;
        bit          found;
        cnt_i           = {21'd0, count};
        first_i         = {22'd0, first};
        run_len         = 0;
        head            = 0;
        found           = 1'b0;
        resp.status     = ST_DONE;
        resp.alloc_page = '0;
        if (cnt_i == 0) begin
            resp.status = ST_BAD;
        end else if (op == OP_ALLOC) begin
            if (cnt_i <= N_PAGES) begin
                for (int p = 0; p < N_PAGES && !found; p++) begin
                    if (!used_map[p[9:0]]) begin
                        if (run_len == 0) head = p;
                        run_len++;
                        if (run_len == cnt_i) found = 1'b1;
                    end else begin
                        run_len = 0;
                    end
                end
            end
            if (found) begin
                for (int p = head; p < head + cnt_i; p++) used_map[p[9:0]] = 1'b1;
                resp.alloc_page = head[9:0];
                live_runs.push_back('{head, cnt_i});
            end else begin
                resp.status = ST_NOSPACE;
            end
        end else begin
            if (first_i + cnt_i > N_PAGES) begin
                resp.status = ST_BAD;
            end else begin
                for (int p = first_i; p < first_i + cnt_i; p++) used_map[p[9:0]] = 1'b0;
            end
        end
    endtask

    // mostly frees of live runs and small allocations, plus bad requests and a periodic free of the whole map
    task automatic pick_random_request(output t_opcode op, output logic [10:0] count,
                                       output logic [9:0] first);
        int r;
        int free_pct;
        int idx;
        int unsigned f;
        r     = $urandom_range(0, 99);
        first = 10'($urandom);
        if ((req_idx - N_DIR) % 150 == 149) begin
            op    = OP_FREE;
            count = 11'd1024;
            first = '0;
            live_runs.delete();
        end else if (r < 3) begin
            op    = OP_ALLOC;
            count = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
        end else if (r < 6) begin
            op = OP_FREE;
            if ($urandom_range(0, 2) == 0) begin
                count = '0;
            end else begin
                f     = {22'd0, first};
                count = 11'($urandom_range(N_PAGES - f + 1, 2047));
            end
        end else begin
            if (live_runs.size() == 0) free_pct = 5;
            else if (live_runs.size() > 20) free_pct = 60;
            else free_pct = 35;
            if ($urandom_range(0, 99) < free_pct) begin
                op = OP_FREE;
                if (live_runs.size() > 0 && $urandom_range(0, 99) < 80) begin
                    idx   = $urandom_range(0, live_runs.size() - 1);
                    first = live_runs[idx].first[9:0];
                    count = live_runs[idx].count[10:0];
                    live_runs.delete(idx);
                end else begin
                    f     = {22'd0, first};
                    count = 11'($urandom_range(1, (N_PAGES - f < 32) ? N_PAGES - f : 32));
                end
            end else begin
                op = OP_ALLOC;
                r  = $urandom_range(0, 99);
                if (r < 75) count = 11'($urandom_range(1, 8));
                else if (r < 95) count = 11'($urandom_range(9, 64));
                else count = 11'($urandom_range(65, 1024));
            end
        end
    endtask

    // request side
    always @(posedge i_clk) begin
        t_opcode     op;
        logic [10:0] count;
        logic [9:0]  first;
        t_resp       pred;
        logic        valid_nxt;
        valid_nxt = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_allocation(t_opcode'(i_opcode), i_num_pages, i_first_page, pred);
                expected_resp_q.push_back(cur_typed ? cur_typed_resp : pred);
                valid_nxt = 1'b0;
                in_gap    = pick_gap();
            end
            if (!valid_nxt && req_idx < N_TOTAL) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else begin
                    if (req_idx < N_DIR) begin
                        op        = dir_table[req_idx[4:0]].op;
                        count     = dir_table[req_idx[4:0]].count;
                        first     = dir_table[req_idx[4:0]].first;
                        cur_typed = dir_table[req_idx[4:0]].typed;
                        cur_typed_resp.status     = dir_table[req_idx[4:0]].status;
                        cur_typed_resp.alloc_page = dir_table[req_idx[4:0]].alloc_page;
                    end else begin
                        pick_random_request(op, count, first);
                        cur_typed = 1'b0;
                    end
                    req_idx++;
                    if (quiet_left > 0) quiet_left--;
                    else if ($urandom_range(0, 99) < 2) quiet_left = $urandom_range(20, 60);
                    i_opcode     <= op;
                    i_num_pages  <= count;
                    i_first_page <= first;
                    valid_nxt = 1'b1;
                end
            end
            all_sent = (req_idx == N_TOTAL) && !valid_nxt;
        end
        i_in_valid <= valid_nxt;
    end

    // response side
    always @(posedge i_clk) begin
        t_resp exp_resp;
        int    gap;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_resp_q.size() == 0) begin
                $error("unexpected response: status %0d alloc_page %0d",
                       o_status, o_alloc_page);
                fail_count++;
            end else begin
                exp_resp = expected_resp_q.pop_front();
                if (o_status !== exp_resp.status) begin
                    $error("status: expected %0d, got %0d", exp_resp.status, o_status);
                    fail_count++;
                end
                if (o_alloc_page !== exp_resp.alloc_page) begin
                    $error("alloc_page: expected %0d, got %0d",
                           exp_resp.alloc_page, o_alloc_page);
                    fail_count++;
                end
            end
        end
        if (out_hold > 0) begin
            out_hold--;
        end else begin
            gap = pick_gap();
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                out_hold = gap - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_count = 0;
            end else begin
                idle_count++;
            end
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!(all_sent && expected_resp_q.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_resp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
